### design/kms_pkg.sv
// Shared constants, key code table and control types for the keypad matrix scanner.
package kms_pkg;

  // Default geometry
  localparam int unsigned ROWS_DEF  = 5;
  localparam int unsigned COLS_DEF  = 4;
  localparam int unsigned SLOTS_DEF = 6;

  // Fixed field widths and counts
  localparam int unsigned OUT_SLOTS = 6;
  localparam int unsigned CODE_W    = 8;
  localparam int unsigned COL_IN_W  = 4;
  localparam int unsigned ROW_OUT_W = 3;
  localparam int unsigned ROM_SIZE  = 20;
  localparam int unsigned S_DATA_W  = 8;
  localparam int unsigned M_DATA_W  = 56;

  // Debounce threshold after reset
  localparam logic [7:0] THRESH_RESET = 8'd5;

  // Command codes carried on tuser
  localparam logic CMD_SCAN = 1'b0;
  localparam logic CMD_SEND = 1'b1;

  // Config register map (index taken from paddr[2])
  localparam logic REG_THRESH = 1'b0;

  // Usage codes, indexed by row*COLS+col; 0 = unmapped
  localparam logic [7:0] KEYCODE_ROM [ROM_SIZE] = '{
    8'h53, 8'h54, 8'h55, 8'h56,
    8'h5f, 8'h60, 8'h61, 8'h57,
    8'h5c, 8'h5d, 8'h5e, 8'h00,
    8'h59, 8'h5a, 8'h5b, 8'h58,
    8'h62, 8'h00, 8'h63, 8'h00
  };

  // Code lookup; keys past the table are unmapped
  function automatic logic [7:0] keycode(input logic [7:0] key);
    logic [7:0] code;
    code = 8'h00;
    if (key < 8'(ROM_SIZE)) begin
      code = KEYCODE_ROM[key[4:0]];
    end
    return code;
  endfunction

  // Controller to datapath strobes
  typedef struct packed {
    logic accept;   // input transaction taken this cycle
    logic upd;      // count update and release for current column
    logic ins;      // insertion check for current column
    logic finish;   // load the result register
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_send;  // item on the input port is a send request
    logic out_free; // result register can take a new result
  } dp_status_t;

endpackage

### design/kms_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kms_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 20,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/kms_ctrl.sv
// Sequencer for scan and send transactions: column walk over update and insert phases.
module kms_ctrl #(
  parameter int unsigned COLS = kms_pkg::COLS_DEF,
  localparam int unsigned CW = (COLS > 1) ? $clog2(COLS) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_valid_i,
  output logic                   s_ready_o,
  input  kms_pkg::dp_status_t    status_i,
  output kms_pkg::ctrl_cmd_t     cmd_o,
  output logic [CW-1:0]          col_o,
  output logic [CW-1:0]          rd_col_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_INSERT,
    ST_DONE
  } state_e;

  state_e        state_q;
  logic [CW-1:0] col_q;
  logic          last_col;

  assign last_col  = (col_q == CW'(COLS - 1));
  assign s_ready_o = (state_q == ST_IDLE);
  assign col_o     = col_q;

  // Strobes decoded from state
  always_comb begin
    cmd_o.accept = (state_q == ST_IDLE) && s_valid_i;
    cmd_o.upd    = (state_q == ST_UPDATE);
    cmd_o.ins    = (state_q == ST_INSERT);
    cmd_o.finish = (state_q == ST_DONE) && status_i.out_free;
    // Prefetch next column's count while updating the current one
    rd_col_o     = '0;
    if (state_q == ST_UPDATE && !last_col) begin
      rd_col_o = col_q + CW'(1);
    end
  end

  // State and column counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      col_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          col_q <= '0;
          if (s_valid_i) begin
            // tuser is latched at this edge; decide from the port directly
            state_q <= status_i.is_send ? ST_DONE : ST_READ;
          end
        end
        ST_READ: begin
          state_q <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (last_col) begin
            col_q   <= '0;
            state_q <= ST_INSERT;
          end else begin
            col_q <= col_q + CW'(1);
          end
        end
        ST_INSERT: begin
          if (last_col) begin
            col_q   <= '0;
            state_q <= ST_DONE;
          end else begin
            col_q <= col_q + CW'(1);
          end
        end
        ST_DONE: begin
          if (status_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### design/kms_dpath.sv
// Datapath: press counters, report slots, row pointer and result register.
module kms_dpath #(
  parameter int unsigned ROWS  = kms_pkg::ROWS_DEF,
  parameter int unsigned COLS  = kms_pkg::COLS_DEF,
  parameter int unsigned SLOTS = kms_pkg::SLOTS_DEF,
  localparam int unsigned CW    = (COLS > 1) ? $clog2(COLS) : 1,
  localparam int unsigned RW    = (ROWS > 1) ? $clog2(ROWS) : 1,
  localparam int unsigned NKEYS = ROWS * COLS,
  localparam int unsigned KW    = (NKEYS > 1) ? $clog2(NKEYS) : 1,
  localparam int unsigned SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  kms_pkg::ctrl_cmd_t             cmd_i,
  input  logic [CW-1:0]                  col_i,
  input  logic [CW-1:0]                  rd_col_i,
  input  logic [7:0]                     thresh_i,
  input  logic [kms_pkg::COL_IN_W-1:0]   col_bits_i,
  input  logic                           command_i,
  output kms_pkg::dp_status_t            status_o,
  output logic                           m_valid_o,
  input  logic                           m_ready_i,
  output logic [kms_pkg::M_DATA_W-1:0]   m_data_o,
  output logic                           m_user_o
);

  logic                          send_q;
  logic [kms_pkg::COL_IN_W-1:0]  cols_q;
  logic [RW-1:0]                 row_q;
  logic [RW-1:0]                 next_row;
  logic                          changed_q;
  logic [7:0]                    slots_q [SLOTS];
  logic [NKEYS-1:0]              valid_q;
  logic [COLS-1:0]               over_q;
  logic                          m_valid_q;
  logic [kms_pkg::M_DATA_W-1:0]  m_data_q;
  logic                          m_user_q;
  logic [kms_pkg::M_DATA_W-1:0]  m_data_d;
  logic                          report;

  logic [KW-1:0] cur_key;
  logic [KW-1:0] rd_key;
  logic [7:0]    code;
  logic [7:0]    ram_rdata;
  logic [7:0]    cnt;
  logic [7:0]    new_cnt;
  logic [15:0]   cols_ext;
  logic          pressed;
  logic          hit_found;
  logic [SW-1:0] hit_idx;
  logic          emp_found;
  logic [SW-1:0] emp_idx;

  // Key addresses for the current and prefetched column
  assign cur_key = KW'(row_q) * KW'(COLS) + KW'(col_i);
  assign rd_key  = KW'(row_q) * KW'(COLS) + KW'(rd_col_i);
  assign code    = kms_pkg::keycode(8'(cur_key));

  assign next_row = (row_q == RW'(ROWS - 1)) ? '0 : row_q + RW'(1);

  // Count update; columns past the input width read as released
  assign cols_ext = 16'(cols_q);
  assign pressed  = cols_ext[4'(col_i)];
  assign cnt      = valid_q[cur_key] ? ram_rdata : 8'h00;
  always_comb begin
    new_cnt = 8'h00;
    if (pressed) begin
      new_cnt = (cnt == 8'hff) ? cnt : cnt + 8'd1;
    end
  end

  kms_ram #(
    .WIDTH (8),
    .DEPTH (NKEYS)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.upd),
    .waddr_i (cur_key),
    .wdata_i (new_cnt),
    .raddr_i (rd_key),
    .rdata_o (ram_rdata)
  );

  // First slot holding the current code, and first empty slot
  always_comb begin
    hit_found = 1'b0;
    hit_idx   = '0;
    emp_found = 1'b0;
    emp_idx   = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (!hit_found && slots_q[s] == code) begin
        hit_found = 1'b1;
        hit_idx   = SW'(s);
      end
      if (!emp_found && slots_q[s] == 8'h00) begin
        emp_found = 1'b1;
        emp_idx   = SW'(s);
      end
    end
  end

  // Result word: six slots then drive_row
  assign report = send_q && changed_q;
  always_comb begin
    m_data_d = '0;
    for (int i = 0; i < kms_pkg::OUT_SLOTS; i++) begin
      if (i < SLOTS && report) begin
        m_data_d[8*i +: 8] = slots_q[i];
      end
    end
    m_data_d[8*kms_pkg::OUT_SLOTS +: kms_pkg::ROW_OUT_W] =
      send_q ? kms_pkg::ROW_OUT_W'(row_q) : kms_pkg::ROW_OUT_W'(next_row);
  end

  // Control state: row, slots, flag, count valid bits, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q     <= '0;
      changed_q <= 1'b0;
      valid_q   <= '0;
      m_valid_q <= 1'b0;
      for (int s = 0; s < SLOTS; s++) begin
        slots_q[s] <= 8'h00;
      end
    end else begin
      if (cmd_i.upd) begin
        valid_q[cur_key] <= 1'b1;
        // release removes a mapped key's code from the report
        if (!pressed && code != 8'h00 && hit_found) begin
          slots_q[hit_idx] <= 8'h00;
          changed_q        <= 1'b1;
        end
      end
      if (cmd_i.ins) begin
        if (over_q[col_i] && !hit_found && emp_found) begin
          slots_q[emp_idx] <= code;
          changed_q        <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        m_valid_q <= 1'b1;
        if (send_q) begin
          changed_q <= 1'b0;
        end else begin
          row_q <= next_row;
        end
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      send_q <= (command_i == kms_pkg::CMD_SEND);
      cols_q <= col_bits_i;
    end
    if (cmd_i.upd) begin
      over_q[col_i] <= pressed && (new_cnt > thresh_i) && (code != 8'h00);
    end
    if (cmd_i.finish) begin
      m_data_q <= m_data_d;
      m_user_q <= report;
    end
  end

  assign status_o.is_send  = (command_i == kms_pkg::CMD_SEND);
  assign status_o.out_free = !m_valid_q || m_ready_i;
  assign m_valid_o         = m_valid_q;
  assign m_data_o          = m_data_q;
  assign m_user_o          = m_user_q;

endmodule

### design/keypad_matrix_scan_6key_report_top.sv
// Top level of the keypad matrix scanner with six-slot key report.
//
// Input stream: one transaction per item. tuser = command (0 scan the driven
// row, 1 request a report), tdata[3:0] = column levels of the driven row.
// Output stream: one transaction per input item. tuser = report_valid,
// tdata = six 8-bit slot codes (slot zero lowest) then the 3-bit row to drive.
// A scan item walks the columns twice through one count RAM port: count
// update and release (one column a cycle, preceded by a read state), then
// insertion (one column a cycle). A send item goes straight to loading the
// result. The next item is accepted in the cycle after the result is
// loaded.
// Reset clears all counts, empties the slots, clears the change flag, selects
// row 0 and sets the debounce threshold to 5.
// A stalled receiver holds the result in the output register; the next item
// is processed meanwhile and waits in its final state until that register frees.
// APB: debounce_threshold at byte address 0; pready is always high.
module keypad_matrix_scan_6key_report_top #(
  parameter int unsigned ROWS  = kms_pkg::ROWS_DEF,
  parameter int unsigned COLS  = kms_pkg::COLS_DEF,
  parameter int unsigned SLOTS = kms_pkg::SLOTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [kms_pkg::S_DATA_W-1:0]  s_axis_tdata,  // [3:0] column_bits
  input  logic                          s_axis_tuser,  // [0] command
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [kms_pkg::M_DATA_W-1:0]  m_axis_tdata,  // slot_zero..slot_five, drive_row
  output logic                          m_axis_tuser,  // [0] report_valid
  // config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int unsigned CW = (COLS > 1) ? $clog2(COLS) : 1;

  kms_pkg::ctrl_cmd_t  cmd;
  kms_pkg::dp_status_t status;
  logic [CW-1:0]       col;
  logic [CW-1:0]       rd_col;
  logic [7:0]          thresh_q;

  // Config register
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= kms_pkg::THRESH_RESET;
    end else if (psel && penable && pwrite && paddr[2] == kms_pkg::REG_THRESH) begin
      thresh_q <= pwdata[7:0];
    end
  end
  assign prdata = (paddr[2] == kms_pkg::REG_THRESH) ? 32'(thresh_q) : 32'h0;

  kms_ctrl #(
    .COLS (COLS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd),
    .col_o     (col),
    .rd_col_o  (rd_col)
  );

  kms_dpath #(
    .ROWS  (ROWS),
    .COLS  (COLS),
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .col_i      (col),
    .rd_col_i   (rd_col),
    .thresh_i   (thresh_q),
    .col_bits_i (s_axis_tdata[kms_pkg::COL_IN_W-1:0]),
    .command_i  (s_axis_tuser),
    .status_o   (status),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_o   (m_axis_tdata),
    .m_user_o   (m_axis_tuser)
  );

endmodule

### test/tb_keypad_matrix_scan_6key_report_top.sv
// Testbench for the keypad matrix scanner: directed table, then randomized key activity.
`timescale 1ns / 100ps

module tb_keypad_matrix_scan_6key_report_top;

  localparam int NUM_ROWS  = kms_pkg::ROWS_DEF;
  localparam int NUM_COLS  = kms_pkg::COLS_DEF;
  localparam int NUM_SLOTS = kms_pkg::SLOTS_DEF;
  localparam int NUM_KEYS  = NUM_ROWS * NUM_COLS;
  localparam int CYCLE_LIMIT = 800000;
  localparam int NO_TYPED = -1;

  // APB byte addresses
  localparam logic [2:0] ADDR_THRESH = {kms_pkg::REG_THRESH, 2'b00};
  localparam logic [2:0] ADDR_SPARE  = 3'd4;

  // Keypad usage codes by row*cols+col, 0 = unmapped
  localparam logic [7:0] USAGE_CODE [NUM_KEYS] = '{
    8'h53, 8'h54, 8'h55, 8'h56,
    8'h5f, 8'h60, 8'h61, 8'h57,
    8'h5c, 8'h5d, 8'h5e, 8'h00,
    8'h59, 8'h5a, 8'h5b, 8'h58,
    8'h62, 8'h00, 8'h63, 8'h00
  };

  typedef struct packed {
    logic            valid;
    logic [5:0][7:0] slots;
    logic [2:0]      row;
  } report_t;

  typedef struct {
    bit         set_thr;
    logic [7:0] thr;
    logic       cmd;
    logic [3:0] cols;
    int         exp_row;  // NO_TYPED: take the predictor's result
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [3:0] column_bits, [7:4] zero
  logic        s_axis_tuser = 1'b0; // [0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;        // slot_zero..slot_five, [50:48] drive_row
  logic        m_axis_tuser;        // [0] report_valid
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Mirror of the scanner state
  logic [7:0]      press_tally [NUM_KEYS];
  logic [5:0][7:0] buf_codes;
  logic            buf_dirty;
  logic [2:0]      cur_row;
  logic [7:0]      thr_model;

  report_t   pending_reports [$];
  stim_row_t directed_rows [$];

  bit idle_on;
  bit key_held [NUM_KEYS];
  int mismatch_count;
  int items_sent;
  int results_seen;
  int reports_seen;
  int thr_settings;
  int cycle_count;

  keypad_matrix_scan_6key_report_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (mismatch_count < 40) begin
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h (cycle %0d)", what, got, want,
               cycle_count);
    end
    mismatch_count++;
  endtask

  // Advance the mirrored state by one transaction and return its result
  function automatic report_t predict_report(input logic cmd, input logic [3:0] cols);
    report_t    r;
    int         key;
    logic [7:0] code;
    logic       hit;
    r = '0;
    if (cmd == kms_pkg::CMD_SEND) begin
      if (buf_dirty) begin
        buf_dirty = 1'b0;
        r.valid   = 1'b1;
        r.slots   = buf_codes;
      end
      r.row = cur_row;
      return r;
    end
    // releases and counts first, in column order
    for (int c = 0; c < NUM_COLS; c++) begin
      key = cur_row * NUM_COLS + c;
      code = USAGE_CODE[key];
      if (cols[c]) begin
        if (press_tally[key] != 8'hff) press_tally[key] = press_tally[key] + 8'd1;
      end else begin
        press_tally[key] = 8'd0;
        hit = 1'b0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (!hit && code != 8'd0 && buf_codes[s] == code) begin
            buf_codes[s] = 8'd0;
            buf_dirty = 1'b1;
            hit = 1'b1;
          end
        end
      end
    end
    // then insertions into the first free slot
    for (int c = 0; c < NUM_COLS; c++) begin
      key = cur_row * NUM_COLS + c;
      code = USAGE_CODE[key];
      if (press_tally[key] > thr_model && code != 8'd0) begin
        hit = 1'b0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (buf_codes[s] == code) hit = 1'b1;
        end
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (!hit && buf_codes[s] == 8'd0) begin
            buf_codes[s] = code;
            buf_dirty = 1'b1;
            hit = 1'b1;
          end
        end
      end
    end
    cur_row = (cur_row == 3'(NUM_ROWS - 1)) ? 3'd0 : cur_row + 3'd1;
    r.row = cur_row;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 15);
    if (r < 9) return 0;
    if (r < 15) return $urandom_range(1, 3);
    return $urandom_range(16, 48);
  endfunction

  function automatic void add_row(input bit set_thr, input logic [7:0] thr,
                                  input logic cmd, input logic [3:0] cols,
                                  input int exp_row);
    stim_row_t row;
    row.set_thr = set_thr;
    row.thr     = thr;
    row.cmd     = cmd;
    row.cols    = cols;
    row.exp_row = exp_row;
    directed_rows.push_back(row);
  endfunction

  // One APB transfer: setup cycle, access until pready, then back to idle
  task automatic apb_xfer(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic drain_stream();
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_threshold(input logic [7:0] thr);
    logic [31:0] rd;
    apb_xfer(1'b1, ADDR_THRESH, {8'($urandom), 8'($urandom), 8'($urandom), thr}, rd);
    thr_model = thr;
    thr_settings++;
    apb_xfer(1'b0, ADDR_THRESH, 32'd0, rd);
    if (rd !== {24'd0, thr}) flag_mismatch("threshold readback", int'(rd), int'(thr));
  endtask

  // Present one item, hold it until accepted, then queue its expected result
  task automatic drive_item(input logic cmd, input logic [3:0] cols, input int exp_row);
    int      gap;
    report_t r;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {4'd0, cols};
    do @(posedge clk_i); while (!s_axis_tready);
    r = predict_report(cmd, cols);
    if (exp_row != NO_TYPED) begin
      r = '0;
      r.row = exp_row[2:0];
    end
    pending_reports.push_back(r);
    items_sent++;
  endtask

  // Random key activity for one threshold setting
  task automatic run_phase(input logic [7:0] thr, input int n_items, input bit idling,
                           input int sticky_key);
    logic [3:0] cols;
    int         key;
    drain_stream();
    set_threshold(thr);
    idle_on = idling;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 5) == 0) begin
        drive_item(kms_pkg::CMD_SEND, 4'($urandom), NO_TYPED);
      end else if ($urandom_range(0, 4) == 0) begin
        drive_item(kms_pkg::CMD_SCAN, 4'($urandom), NO_TYPED);
      end else begin
        // held keys with occasional press or release
        for (int c = 0; c < NUM_COLS; c++) begin
          key = cur_row * NUM_COLS + c;
          if (key == sticky_key) key_held[key] = 1'b1;
          else if ($urandom_range(0, 5) == 0) key_held[key] = !key_held[key];
          cols[c] = key_held[key];
        end
        drive_item(kms_pkg::CMD_SCAN, cols, NO_TYPED);
      end
    end
  endtask

  // Receiver with random stalls
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        hold--;
      end else begin
        m_axis_tready <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  // Compare each output transaction with the oldest expectation
  always @(posedge clk_i) begin
    report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (m_axis_tuser === 1'b1) reports_seen++;
      if (pending_reports.size() == 0) begin
        flag_mismatch("result with nothing expected", int'(m_axis_tdata[50:48]), 0);
      end else begin
        want = pending_reports.pop_front();
        if (m_axis_tuser !== want.valid)
          flag_mismatch("report_valid", int'(m_axis_tuser), int'(want.valid));
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (m_axis_tdata[s*8 +: 8] !== want.slots[s])
            flag_mismatch($sformatf("slot %0d", s), int'(m_axis_tdata[s*8 +: 8]),
                          int'(want.slots[s]));
        end
        if (m_axis_tdata[50:48] !== want.row)
          flag_mismatch("drive_row", int'(m_axis_tdata[50:48]), int'(want.row));
      end
    end
  end

  // Run limit
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
             pending_reports.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [31:0] rd;
    cycle_count = 0;
    mismatch_count = 0;
    items_sent = 0;
    results_seen = 0;
    reports_seen = 0;
    thr_settings = 0;
    idle_on = 1'b1;
    for (int k = 0; k < NUM_KEYS; k++) begin
      press_tally[k] = 8'd0;
      key_held[k] = 1'b0;
    end
    buf_codes = '0;
    buf_dirty = 1'b0;
    cur_row   = 3'd0;
    thr_model = kms_pkg::THRESH_RESET;

    // Directed table; small numbers are the drive_row of an empty, non-valid result
    add_row(0, 0,   kms_pkg::CMD_SEND, 4'h0, 0);        // send right after reset
    add_row(0, 0,   kms_pkg::CMD_SCAN, 4'h0, 1);
    add_row(0, 0,   kms_pkg::CMD_SCAN, 4'hf, 2);        // below default threshold
    add_row(1, 0,   kms_pkg::CMD_SCAN, 4'hf, 3);        // row 2, unmapped col 3
    add_row(0, 0,   kms_pkg::CMD_SCAN, 4'hf, 4);        // row 3 fills the buffer
    add_row(0, 0,   kms_pkg::CMD_SCAN, 4'hf, 0);        // full buffer drops keys
    add_row(0, 0,   kms_pkg::CMD_SEND, 4'h0, NO_TYPED);
    add_row(0, 0,   kms_pkg::CMD_SEND, 4'hf, 0);        // flag already cleared
    add_row(0, 0,   kms_pkg::CMD_SCAN, 4'h0, 1);
    add_row(0, 0,   kms_pkg::CMD_SCAN, 4'hf, 2);
    add_row(0, 0,   kms_pkg::CMD_SCAN, 4'h5, NO_TYPED); // releases incl. unmapped
    add_row(0, 0,   kms_pkg::CMD_SCAN, 4'hb, NO_TYPED); // release before insert
    add_row(0, 0,   kms_pkg::CMD_SEND, 4'h0, NO_TYPED);
    add_row(0, 0,   kms_pkg::CMD_SCAN, 4'ha, NO_TYPED); // unmapped keys held
    add_row(0, 0,   kms_pkg::CMD_SEND, 4'h0, 0);
    add_row(0, 0,   kms_pkg::CMD_SCAN, 4'he, NO_TYPED);
    add_row(0, 0,   kms_pkg::CMD_SCAN, 4'h0, NO_TYPED);
    add_row(0, 0,   kms_pkg::CMD_SCAN, 4'h0, NO_TYPED);
    add_row(1, 255, kms_pkg::CMD_SCAN, 4'hf, NO_TYPED); // nothing can be added
    add_row(0, 0,   kms_pkg::CMD_SCAN, 4'hf, NO_TYPED);
    add_row(0, 0,   kms_pkg::CMD_SEND, 4'h0, NO_TYPED);
    add_row(1, 254, kms_pkg::CMD_SCAN, 4'h0, NO_TYPED);
    add_row(0, 0,   kms_pkg::CMD_SEND, 4'h0, NO_TYPED);
    add_row(0, 0,   kms_pkg::CMD_SEND, 4'h0, NO_TYPED);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_thr) begin
        drain_stream();
        set_threshold(directed_rows[i].thr);
      end
      drive_item(directed_rows[i].cmd, directed_rows[i].cols, directed_rows[i].exp_row);
    end

    // A write to the unused address must leave the threshold alone
    drain_stream();
    apb_xfer(1'b1, ADDR_SPARE, $urandom, rd);
    apb_xfer(1'b0, ADDR_THRESH, 32'd0, rd);
    if (rd !== {24'd0, thr_model})
      flag_mismatch("threshold after spare write", int'(rd), int'(thr_model));

    // Random part; one key is held in the key-activity items so its count can climb
    begin
      int sticky;
      sticky = $urandom_range(0, NUM_KEYS - 1);
      run_phase(8'($urandom_range(1, 10)), 400, 1'b1, sticky);
      run_phase(8'd0, 300, 1'b1, sticky);
      run_phase(8'd1, 200, 1'b0, sticky);
      run_phase(8'd255, 100, 1'b1, sticky);
      run_phase(8'd254, 600, 1'b1, sticky);
    end

    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Drove %0d scan and send transactions under %0d threshold settings",
             items_sent, thr_settings);
    $display("Compared %0d results, %0d of them carrying a report", results_seen,
             reports_seen);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
